>>> hw/rtl/scvg_pkg.sv
// ----------------------------------------------------------------------------
// scvg_pkg
// shared types, constants and tables of the scale chord voicing generator
// ----------------------------------------------------------------------------
`default_nettype none

package scvg_pkg;

  localparam int MAX_DEGREES = 64;
  localparam int MAX_VOICES  = 12;
  localparam int CNT_W       = $clog2(MAX_DEGREES + 1);
  localparam int DEG_W       = $clog2(MAX_DEGREES);
  localparam int VIDX_W      = $clog2(MAX_VOICES);
  localparam int NOTE_W      = 11;
  localparam int SHIFT_W     = 5;
  localparam int THR_W       = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] MODE_FREE    = 3'd0;
  localparam logic [2:0] MODE_CLOSE   = 3'd1;
  localparam logic [2:0] MODE_OPEN    = 3'd2;
  localparam logic [2:0] MODE_DROP2   = 3'd3;
  localparam logic [2:0] MODE_THIRDS  = 3'd4;
  localparam logic [2:0] MODE_QUARTAL = 3'd5;
  localparam logic [2:0] MODE_QUINTAL = 3'd6;

  localparam logic [2:0] REG_KEY_OFFSET   = 3'd0;
  localparam logic [2:0] REG_DEGREE_COUNT = 3'd1;
  localparam logic [2:0] REG_DEGREE_MASK  = 3'd2;
  localparam logic [2:0] REG_VOICING_MODE = 3'd3;
  localparam logic [2:0] REG_VOICE_COUNT  = 3'd4;

  typedef enum logic [2:0] {FE_IDLE, FE_MOD, FE_SCAN, FE_LIST, FE_PUSH} fe_state_t;
  typedef enum logic [1:0] {BK_IDLE, BK_GEN, BK_RANK, BK_EMIT} bk_state_t;

  typedef struct packed {
    logic                                 fallback;
    logic [6:0]                           root;
    logic [CNT_W-1:0]                     cnt;
    logic [2:0]                           mode;
    logic [VIDX_W-1:0]                    n;
    logic [CNT_W-1:0]                     a;
    logic [5:0]                           step;
    logic [MAX_VOICES-1:0][DEG_W-1:0]     iv;
  } job_t;

  // floor(55705 / n) and 55705 mod n for n = 1 .. 12
  function automatic logic [THR_W-1:0] thr_quot(input logic [VIDX_W-1:0] n);
    logic [THR_W-1:0] q;
    case (n)
      4'd1:    q = 16'd55705;
      4'd2:    q = 16'd27852;
      4'd3:    q = 16'd18568;
      4'd4:    q = 16'd13926;
      4'd5:    q = 16'd11141;
      4'd6:    q = 16'd9284;
      4'd7:    q = 16'd7957;
      4'd8:    q = 16'd6963;
      4'd9:    q = 16'd6189;
      4'd10:   q = 16'd5570;
      4'd11:   q = 16'd5064;
      4'd12:   q = 16'd4642;
      default: q = 16'd0;
    endcase
    return q;
  endfunction

  function automatic logic [VIDX_W-1:0] thr_rem(input logic [VIDX_W-1:0] n);
    logic [VIDX_W-1:0] r;
    case (n)
      4'd7:    r = 4'd6;
      4'd9:    r = 4'd4;
      4'd10:   r = 4'd5;
      4'd1:    r = 4'd0;
      4'd5:    r = 4'd0;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scvg_front.sv
// ----------------------------------------------------------------------------
// scvg_front
// accepts a note, finds its degree and nearest enabled degree, builds intervals
// ----------------------------------------------------------------------------
`default_nettype none

module scvg_front import scvg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              note_valid,
  output logic              note_ready,
  input  logic [6:0]        played_note,
  input  logic [6:0]        key_offset,
  input  logic [6:0]        degree_count,
  input  logic [63:0]       degree_mask,
  input  logic [2:0]        voicing_mode,
  input  logic [3:0]        voice_count,
  output logic              push_valid,
  input  logic              push_ready,
  output job_t              push_job
);

  fe_state_t state, state_next;

  logic                       fallback;
  logic [6:0]                 root;
  logic [CNT_W-1:0]           cnt;
  logic [2:0]                 mode;
  logic [VIDX_W-1:0]          n;
  logic [MAX_DEGREES-1:0]     mask;
  logic signed [8:0]          v;
  logic [DEG_W-1:0]           deg;
  logic [CNT_W-1:0]           d;
  logic [DEG_W-1:0]           best;
  logic [CNT_W-1:0]           bestd;
  logic [DEG_W-1:0]           dd;
  logic [CNT_W-1:0]           a;
  logic [MAX_VOICES-1:0][DEG_W-1:0] iv;

  logic                       accept;
  logic [CNT_W-1:0]           cnt_sat;
  logic [MAX_DEGREES-1:0]     mask_eff;
  logic signed [8:0]          cnt_s;
  logic                       mod_done;
  logic [CNT_W-1:0]           diff, alt, circ_dist;
  logic                       better;
  logic [DEG_W-1:0]           best_upd;
  logic                       last_d;
  logic [3:0]                 k;
  logic [8:0]                 x;
  logic [18:0]                prod;
  logic [5:0]                 step;

  assign accept  = note_valid && note_ready;
  assign cnt_sat = (degree_count > CNT_W'(MAX_DEGREES)) ? CNT_W'(MAX_DEGREES) : degree_count;
  assign mask_eff = (cnt_sat >= CNT_W'(MAX_DEGREES)) ? degree_mask :
                    (degree_mask & ((64'd1 << cnt_sat) - 64'd1));
  assign cnt_s    = $signed({2'b00, cnt});
  assign mod_done = (v >= 9'sd0) && (v < cnt_s);

  assign diff      = ({1'b0, deg} >= d) ? ({1'b0, deg} - d) : (d - {1'b0, deg});
  assign alt       = cnt - diff;
  assign circ_dist = (alt < diff) ? alt : diff;
  assign better    = mask[d[DEG_W-1:0]] && (circ_dist < bestd);
  assign best_upd  = better ? d[DEG_W-1:0] : best;
  assign last_d    = (d == cnt - CNT_W'(1));

  always_comb begin
    case (mode)
      MODE_THIRDS:  k = 4'd4;
      MODE_QUARTAL: k = 4'd5;
      default:      k = 4'd7;
    endcase
  end

  // step = (cnt*k + 6) / 12 through a reciprocal in the stacked modes (at least 1), else 1
  assign x    = 9'(cnt * k) + 9'd6;
  assign prod = 19'(x * 10'd683);
  assign step = ((mode == MODE_THIRDS || mode == MODE_QUARTAL || mode == MODE_QUINTAL)
                 && prod[18:13] != 6'd0) ? prod[18:13] : 6'd1;

  always_comb begin
    state_next = state;
    case (state)
      FE_IDLE: if (note_valid) begin
        state_next = (cnt_sat == '0 || mask_eff == '0) ? FE_PUSH : FE_MOD;
      end
      FE_MOD:  if (mod_done) state_next = FE_SCAN;
      FE_SCAN: if (last_d) state_next = FE_LIST;
      FE_LIST: if (last_d) state_next = FE_PUSH;
      FE_PUSH: if (push_ready) state_next = FE_IDLE;
      default: state_next = FE_IDLE;
    endcase
  end

  always_comb begin
    note_ready = (state == FE_IDLE);
    push_valid = (state == FE_PUSH);
    push_job.fallback = fallback;
    push_job.root     = root;
    push_job.cnt      = cnt;
    push_job.mode     = mode;
    push_job.n        = n;
    push_job.a        = a;
    push_job.step     = step;
    push_job.iv       = iv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      FE_IDLE: if (accept) begin
        root     <= played_note;
        cnt      <= cnt_sat;
        mask     <= mask_eff;
        mode     <= voicing_mode;
        n        <= (voice_count == 4'd0) ? 4'd1 :
                    (voice_count > 4'(MAX_VOICES)) ? 4'(MAX_VOICES) : voice_count;
        fallback <= (cnt_sat == '0 || mask_eff == '0);
        v        <= $signed({2'b00, played_note}) - 9'sd60
                    - $signed({{2{key_offset[6]}}, key_offset});
      end
      FE_MOD: begin
        if (v < 9'sd0) begin
          v <= v + cnt_s;
        end else if (v >= cnt_s) begin
          v <= v - cnt_s;
        end else begin
          deg   <= v[DEG_W-1:0];
          d     <= '0;
          best  <= '0;
          bestd <= cnt;
        end
      end
      FE_SCAN: begin
        if (better) begin
          best  <= d[DEG_W-1:0];
          bestd <= circ_dist;
        end
        if (last_d) begin
          dd <= best_upd;
          d  <= '0;
          a  <= '0;
        end else begin
          d <= d + CNT_W'(1);
        end
      end
      FE_LIST: begin
        if (mask[dd]) begin
          if (a < CNT_W'(MAX_VOICES)) iv[a[VIDX_W-1:0]] <= d[DEG_W-1:0];
          a <= a + CNT_W'(1);
        end
        dd <= ({1'b0, dd} + CNT_W'(1) == cnt) ? '0 : dd + DEG_W'(1);
        d  <= d + CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/scvg_queue.sv
// ----------------------------------------------------------------------------
// scvg_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module scvg_queue import scvg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  job_t  push_job,
  output logic  pop_valid,
  input  logic  pop_ready,
  output job_t  pop_job
);

  job_t                  mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [QPTR_W:0]       count;
  logic                  do_push, do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scvg_back.sv
// ----------------------------------------------------------------------------
// scvg_back
// generates the voices of a request, orders drop-2 chords, emits results
// ----------------------------------------------------------------------------
`default_nettype none

module scvg_back import scvg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  output logic                      job_ready,
  input  job_t                      job,
  output logic                      voice_valid,
  input  logic                      voice_ready,
  output logic signed [NOTE_W-1:0]  voice_note,
  output logic signed [SHIFT_W-1:0] octave_shift,
  output logic [THR_W-1:0]          threshold,
  output logic                      last_voice
);

  bk_state_t state, state_next;
  job_t      jr;

  logic [VIDX_W-1:0]          nn, i, j, e, ra, fsh, pidx;
  logic [VIDX_W-1:0]          prem, tr;
  logic [THR_W-1:0]           tq;
  logic [8:0]                 sacc;
  logic [CNT_W-1:0]           srem;
  logic [SHIFT_W-1:0]         ssh;

  logic signed [NOTE_W-1:0]   vn   [MAX_VOICES];
  logic signed [SHIFT_W-1:0]  vs   [MAX_VOICES];
  logic [THR_W-1:0]           vt   [MAX_VOICES];
  logic [VIDX_W-1:0]          perm [MAX_VOICES];

  logic                       drop2;
  logic [VIDX_W-1:0]          ividx;
  logic [DEG_W-1:0]           ivv;
  logic signed [NOTE_W-1:0]   root_s, cnt_s, gnote;
  logic signed [SHIFT_W-1:0]  gsh;
  logic [7:0]                 prem_sum, srem_sum;
  logic [VIDX_W:0]            tr_sum;
  logic [VIDX_W-1:0]          rank;
  logic [VIDX_W-1:0]          eidx;
  logic                       dropped, load, last_gen, last_rank, last_emit;

  assign drop2     = (jr.mode == MODE_DROP2) && !jr.fallback;
  assign root_s    = $signed({4'b0000, jr.root});
  assign cnt_s     = $signed({4'b0000, jr.cnt});
  assign last_gen  = (i == nn - VIDX_W'(1));
  assign last_rank = (j == nn - VIDX_W'(1));
  assign last_emit = (e == nn - VIDX_W'(1));
  assign load      = (state == BK_EMIT) && (!voice_valid || voice_ready);

  always_comb begin
    case (jr.mode)
      MODE_CLOSE, MODE_OPEN, MODE_DROP2: ividx = ra;
      default:                           ividx = ({3'b000, jr.n} <= jr.a) ? i : pidx;
    endcase
  end
  assign ivv = jr.iv[ividx];

  always_comb begin
    gnote = root_s;
    gsh   = '0;
    if (!jr.fallback) begin
      case (jr.mode)
        MODE_CLOSE, MODE_DROP2: gnote = root_s + $signed({5'b0, ivv});
        MODE_OPEN: begin
          gsh   = $signed({4'b0000, i[0]});
          gnote = root_s + $signed({5'b0, ivv}) + (i[0] ? cnt_s : 11'sd0);
        end
        MODE_THIRDS, MODE_QUARTAL, MODE_QUINTAL: begin
          gsh   = ssh;
          gnote = root_s + $signed({2'b00, sacc});
        end
        default: begin
          if ({3'b000, jr.n} <= jr.a) begin
            gnote = root_s + $signed({5'b0, ivv});
          end else begin
            gsh   = $signed({1'b0, fsh});
            gnote = root_s + $signed({5'b0, ivv}) + $signed(11'(fsh * jr.cnt));
          end
        end
      endcase
    end
  end

  assign prem_sum = 8'(prem) + 8'(jr.a);
  assign srem_sum = 8'(srem) + 8'(jr.step);
  assign tr_sum   = (VIDX_W+1)'(tr) + (VIDX_W+1)'(thr_rem(nn));

  // stable rank of voice j among the generated notes
  always_comb begin
    rank = '0;
    for (int k = 0; k < MAX_VOICES; k++) begin
      if (VIDX_W'(k) < nn && (vn[k] < vn[j] || (vn[k] == vn[j] && VIDX_W'(k) < j))) begin
        rank = rank + VIDX_W'(1);
      end
    end
  end

  assign eidx    = drop2 ? perm[e] : e;
  assign dropped = drop2 && (nn >= VIDX_W'(2)) && (e == nn - VIDX_W'(2));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (job_valid) state_next = BK_GEN;
      BK_GEN:  if (last_gen) state_next = drop2 ? BK_RANK : BK_EMIT;
      BK_RANK: if (last_rank) state_next = BK_EMIT;
      BK_EMIT: if (load && last_emit) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == BK_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      voice_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        voice_valid <= 1'b1;
      end else if (voice_ready) begin
        voice_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: if (job_valid) begin
        jr   <= job;
        nn   <= job.fallback ? VIDX_W'(1) : job.n;
        i    <= '0;
        ra   <= '0;
        fsh  <= '0;
        pidx <= '0;
        prem <= '0;
        sacc <= '0;
        srem <= '0;
        ssh  <= '0;
        tq   <= '0;
        tr   <= '0;
      end
      BK_GEN: begin
        vn[i] <= gnote;
        vs[i] <= gsh;
        vt[i] <= tq;
        i     <= i + VIDX_W'(1);
        if ({3'b000, ra} + CNT_W'(1) == jr.a) begin
          ra  <= '0;
          fsh <= fsh + VIDX_W'(1);
        end else begin
          ra  <= ra + VIDX_W'(1);
        end
        if (prem_sum >= 8'(nn)) begin
          prem <= VIDX_W'(prem_sum - 8'(nn));
          pidx <= pidx + VIDX_W'(1);
        end else begin
          prem <= VIDX_W'(prem_sum);
        end
        sacc <= sacc + 9'(jr.step);
        if (srem_sum >= 8'(jr.cnt)) begin
          srem <= CNT_W'(srem_sum - 8'(jr.cnt));
          ssh  <= ssh + SHIFT_W'(1);
        end else begin
          srem <= CNT_W'(srem_sum);
        end
        if (tr_sum >= (VIDX_W+1)'(nn)) begin
          tr <= VIDX_W'(tr_sum - (VIDX_W+1)'(nn));
          tq <= tq + thr_quot(nn) + THR_W'(1);
        end else begin
          tr <= VIDX_W'(tr_sum);
          tq <= tq + thr_quot(nn);
        end
        j <= '0;
        e <= '0;
      end
      BK_RANK: begin
        perm[rank] <= j;
        j          <= j + VIDX_W'(1);
      end
      BK_EMIT: if (load) begin
        voice_note   <= vn[eidx] - (dropped ? 11'sd12 : 11'sd0);
        octave_shift <= dropped ? -5'sd1 : vs[eidx];
        threshold    <= vt[eidx];
        last_voice   <= last_emit;
        e            <= e + VIDX_W'(1);
      end
      default: ;
    endcase
  end

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_EMIT) |-> (e < nn))
    else $error("emit index past voice count");

  a_degree_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == BK_GEN && !jr.fallback) |-> ({3'b000, ra} < jr.a))
    else $error("interval index not below enabled degree count");

  a_thr_remainder: assert property (@(posedge clk) disable iff (rst)
    (state == BK_GEN) |-> (tr < nn))
    else $error("threshold remainder not reduced");

  a_rank_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RANK && last_rank) |=> (state == BK_EMIT && e == '0))
    else $error("drop-2 ordering did not hand over to emission");

endmodule

`default_nettype wire

>>> hw/rtl/scale_chord_voicing_generator_top.sv
// ----------------------------------------------------------------------------
// scale_chord_voicing_generator_top
// one played note in, a chord of voices out, configured through an APB port
// ----------------------------------------------------------------------------
// note channel: note_valid/note_ready with played_note; one request per note.
// voice channel: voice_valid/voice_ready with voice_note, octave_shift,
//   threshold and last_voice; last_voice marks the final voice of a chord.
// registers at byte address 8*i: key_offset, degree_count, degree_mask,
//   voicing_mode, voice_count; write only while no chord is in flight.
// front: wraps the note into a degree by adding or taking away the saturated degree
//   count, which takes longest for tiny degree counts; the degree scan and interval
//   list walk one degree a cycle; fallback notes skip all three and go to the push.
// back: builds the voices, ranks them to order a drop-2 chord, then emits one
//   voice a cycle while the receiver takes them.
// a two-entry queue lets the front take the next note while the back emits.
// reset returns registers to their defaults and empties the pipeline.
// a stalled receiver holds the current voice and stops the back; the front
//   keeps going until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module scale_chord_voicing_generator_top import scvg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [5:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  input  logic                      note_valid,
  output logic                      note_ready,
  input  logic [6:0]                played_note,
  output logic                      voice_valid,
  input  logic                      voice_ready,
  output logic signed [NOTE_W-1:0]  voice_note,
  output logic signed [SHIFT_W-1:0] octave_shift,
  output logic [THR_W-1:0]          threshold,
  output logic                      last_voice
);

  logic [6:0]  key_offset;
  logic [6:0]  degree_count;
  logic [63:0] degree_mask;
  logic [2:0]  voicing_mode;
  logic [3:0]  voice_count;
  logic [2:0]  reg_idx;
  logic        wr_en;

  logic  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  job_t  q_push_job, q_pop_job;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_offset   <= 7'd0;
      degree_count <= 7'd12;
      degree_mask  <= 64'hFFF;
      voicing_mode <= MODE_FREE;
      voice_count  <= 4'd3;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY_OFFSET:   key_offset   <= pwdata[6:0];
        REG_DEGREE_COUNT: degree_count <= pwdata[6:0];
        REG_DEGREE_MASK:  degree_mask  <= pwdata;
        REG_VOICING_MODE: voicing_mode <= pwdata[2:0];
        REG_VOICE_COUNT:  voice_count  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_OFFSET:   prdata = {57'd0, key_offset};
      REG_DEGREE_COUNT: prdata = {57'd0, degree_count};
      REG_DEGREE_MASK:  prdata = degree_mask;
      REG_VOICING_MODE: prdata = {61'd0, voicing_mode};
      REG_VOICE_COUNT:  prdata = {60'd0, voice_count};
      default:          prdata = 64'd0;
    endcase
  end

  scvg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .note_valid   (note_valid),
    .note_ready   (note_ready),
    .played_note  (played_note),
    .key_offset   (key_offset),
    .degree_count (degree_count),
    .degree_mask  (degree_mask),
    .voicing_mode (voicing_mode),
    .voice_count  (voice_count),
    .push_valid   (q_push_valid),
    .push_ready   (q_push_ready),
    .push_job     (q_push_job)
  );

  scvg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job)
  );

  scvg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_pop_valid),
    .job_ready    (q_pop_ready),
    .job          (q_pop_job),
    .voice_valid  (voice_valid),
    .voice_ready  (voice_ready),
    .voice_note   (voice_note),
    .octave_shift (octave_shift),
    .threshold    (threshold),
    .last_voice   (last_voice)
  );

endmodule

`default_nettype wire
